/* rtl/rcms_pkg.sv */
// shared types and constants of the radar clutter map subtract block
// used by rcms_ctrl, rcms_dp and radar_clutter_map_subtract_core
package rcms_pkg;

    // field widths
    localparam int SHAFT_W  = 16;
    localparam int BIN_W    = 10;
    localparam int SAMPLE_W = 16;
    localparam int ALPHA_W  = 16;
    localparam int OUT_W    = 17;
    localparam int MAP_W    = 40;
    localparam int CNT_W    = 16;

    // azimuth partitions: 64 of 65536 shaft codes, taken from the code's top bits
    localparam int PART_W    = 6;
    localparam int MAP_AW    = PART_W + BIN_W;
    localparam int MAP_DEPTH = 2 ** MAP_AW;
    localparam int PARTS     = 2 ** PART_W;

    // mean divider: one quotient bit per cycle
    localparam int DIV_STEPS = MAP_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // register map
    localparam int APB_AW = 3;
    localparam logic REG_LEARNING = 1'b0;
    localparam logic REG_ALPHA    = 1'b1;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_FETCH = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ADD   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

    typedef struct packed {
        logic clr;
        logic capture;
        logic rd;
        logic load;
        logic div;
        logic mul;
        logic add;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic need_div;
        logic learning;
        logic out_free;
    } t_sts;

endpackage

/* rtl/rcms_ctrl.sv */
// sequencer of the clutter map block: clearing pass, then one word at a time
// depends on rcms_pkg
module rcms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rcms_pkg::t_sts i_sts,
    output rcms_pkg::t_cmd o_cmd
);
    import rcms_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.load = 1'b1;
                if (i_sts.learning) n_state = S_FIN;
                else if (i_sts.need_div) n_state = S_DIV;
                else n_state = S_MUL;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rcms_dp.sv */
// datapath of the clutter map block: map and count memories, mean divider,
// exponential average update and output register; depends on rcms_pkg
module rcms_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rcms_pkg::t_cmd                         i_cmd,
    output rcms_pkg::t_sts                         o_sts,
    input  logic                                   i_learning,
    input  logic [rcms_pkg::ALPHA_W-1:0]           i_alpha,
    input  logic [rcms_pkg::SHAFT_W-1:0]           i_shaft_encoding,
    input  logic [rcms_pkg::BIN_W-1:0]             i_range_bin,
    input  logic signed [rcms_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                   i_radial_end,
    input  logic                                   i_out_stall,
    output logic                                   o_valid,
    output logic signed [rcms_pkg::OUT_W-1:0]      o_corrected,
    output logic                                   o_corrected_last
);
    import rcms_pkg::*;

    localparam logic signed [MAP_W-1:0] MAP_MAX = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic signed [MAP_W-1:0] MAP_MIN = {1'b1, {(MAP_W-1){1'b0}}};

    // captured word
    logic [PART_W-1:0]          r_part;
    logic [BIN_W-1:0]           r_bin;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;

    // memories
    logic [MAP_W-1:0]  map_mem [MAP_DEPTH];
    logic [CNT_W-1:0]  cnt_mem [PARTS];
    logic signed [MAP_W-1:0] r_cell;
    logic [CNT_W-1:0]  r_cnt;
    logic [MAP_AW-1:0] r_clr_addr;

    // divider
    logic [MAP_W-1:0]  r_quo;
    logic [CNT_W:0]    r_rem;
    logic              r_neg;
    logic [DIV_CW-1:0] r_step;
    logic [CNT_W:0]    div_shift;
    logic [CNT_W:0]    div_sub;
    logic              div_ge;
    logic [MAP_W-1:0]  div_quo;

    // arithmetic
    logic signed [MAP_W-1:0]  r_m;
    logic signed [40:0]       r_p_hi;
    logic [31:0]              r_p_lo;
    logic signed [32:0]       r_p_s;
    logic signed [41:0]       r_u;
    logic signed [42:0]       r_y;
    logic signed [OUT_W-1:0]  r_d;
    logic signed [40:0]       diff_t;
    logic signed [32:0]       diff_q;
    logic signed [42:0]       upd_q;
    logic signed [40:0]       learn_sum;
    logic signed [MAP_W-1:0]  wr_val;
    logic signed [OUT_W-1:0]  res_val;
    logic [CNT_W-1:0]         cnt_val;
    logic signed [16:0]       alpha_s;
    logic                     out_free;
    logic                     fin_go;

    assign alpha_s  = $signed({1'b0, i_alpha});
    assign out_free = !o_valid || !i_out_stall;
    assign fin_go   = i_cmd.fin && out_free;

    // status toward the sequencer
    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_addr == {MAP_AW{1'b1}});
        o_sts.div_last = (r_step == DIV_CW'(DIV_STEPS - 1));
        o_sts.need_div = (r_cnt != '0);
        o_sts.learning = i_learning;
        o_sts.out_free = out_free;
    end

    // word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_part   <= i_shaft_encoding[SHAFT_W-1 -: PART_W];
            r_bin    <= i_range_bin;
            r_sample <= i_sample;
            r_last   <= i_radial_end;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // map memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            map_mem[r_clr_addr] <= '0;
        end else if (fin_go) begin
            map_mem[{r_part, r_bin}] <= wr_val;
        end
        if (i_cmd.rd) begin
            r_cell <= map_mem[{r_part, r_bin}];
        end
    end

    // radial count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            cnt_mem[r_clr_addr[PART_W-1:0]] <= '0;
        end else if (fin_go) begin
            cnt_mem[r_part] <= cnt_val;
        end
        if (i_cmd.rd) begin
            r_cnt <= cnt_mem[r_part];
        end
    end

    // divider step
    always_comb begin
        div_shift = {r_rem[CNT_W-1:0], r_quo[MAP_W-1]};
        div_sub   = div_shift - {1'b0, r_cnt};
        div_ge    = (div_shift >= {1'b0, r_cnt});
        div_quo   = {r_quo[MAP_W-2:0], div_ge};
    end

    // mean: cell as is, or cell over count toward zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= r_cell;
            r_neg  <= r_cell[MAP_W-1];
            r_quo  <= r_cell[MAP_W-1] ? (~r_cell + 1'b1) : r_cell;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div) begin
            r_quo  <= div_quo;
            r_rem  <= div_ge ? div_sub : div_shift;
            r_step <= r_step + 1'b1;
            if (o_sts.div_last) begin
                r_m <= r_neg ? $signed(~div_quo + 1'b1) : $signed(div_quo);
            end
        end
    end

    // partial products of the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_hi <= $signed(r_m[MAP_W-1:16]) * alpha_s;
            r_p_lo <= r_m[15:0] * i_alpha;
            r_p_s  <= r_sample * alpha_s;
        end
    end

    // difference output and update sums
    always_comb begin
        diff_t = $signed({{1{r_sample[SAMPLE_W-1]}}, r_sample, 8'd0}) - 41'(r_m);
        diff_q = diff_t[40] ? 33'((diff_t + 41'sd255) >>> 8) : 33'(diff_t >>> 8);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_u <= 42'(r_m) - 42'(r_p_hi);
            r_y <= (43'(r_p_s) <<< 8) - $signed({11'd0, r_p_lo}) + 43'sd32768;
            if (diff_q > 33'sd65535) r_d <= 17'sd65535;
            else if (diff_q < -33'sd65536) r_d <= -17'sd65536;
            else r_d <= diff_q[OUT_W-1:0];
        end
    end

    // write back values
    always_comb begin
        learn_sum = 41'(r_cell) + 41'($signed({r_sample, 8'd0}));
        upd_q     = 43'(r_u) + (r_y >>> 16);
        wr_val    = r_cell;
        res_val   = OUT_W'(r_sample);
        cnt_val   = r_cnt;
        if (i_learning) begin
            if (learn_sum > 41'(MAP_MAX)) wr_val = MAP_MAX;
            else if (learn_sum < 41'(MAP_MIN)) wr_val = MAP_MIN;
            else wr_val = learn_sum[MAP_W-1:0];
            if (r_last && r_cnt != {CNT_W{1'b1}}) cnt_val = r_cnt + 1'b1;
        end else begin
            if (upd_q > 43'(MAP_MAX)) wr_val = MAP_MAX;
            else if (upd_q < 43'(MAP_MIN)) wr_val = MAP_MIN;
            else wr_val = upd_q[MAP_W-1:0];
            res_val = r_d;
            if (r_last) cnt_val = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (fin_go) begin
            o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            o_corrected      <= res_val;
            o_corrected_last <= r_last;
        end
    end

endmodule

/* rtl/radar_clutter_map_subtract_core.sv */
// Clutter map subtract core: each sample word is added into (learning) or
// subtracted from and averaged into (operating) its partition's map cell.
// One word is in work at a time: while learning it passes capture, read, fetch
// and finish; while operating, multiply and add come before finish, and the
// 40-step bit-serial divider forms the mean first when the radial count of its
// partition is nonzero. A finished word may wait in the output register while
// the next is taken. After reset a clearing pass zeroes every map cell and
// count, and no word is taken until it ends; configuration writes are taken
// at any time. Registers: 0x0 learning (reset 1), 0x4 alpha_q16 (reset 3277).
// depends on rcms_pkg, rcms_ctrl, rcms_dp
module radar_clutter_map_subtract_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rcms_pkg::APB_AW-1:0]           paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input words
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [rcms_pkg::SHAFT_W-1:0]          i_shaft_encoding,
    input  logic [rcms_pkg::BIN_W-1:0]            i_range_bin,
    input  logic signed [rcms_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                  i_radial_end,
    // result words
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [rcms_pkg::OUT_W-1:0]     o_corrected,
    output logic                                  o_corrected_last
);
    import rcms_pkg::*;

    logic               r_learning;
    logic [ALPHA_W-1:0] r_alpha;
    logic               reg_sel;
    t_cmd               cmd;
    t_sts               sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning <= 1'b1;
            r_alpha    <= ALPHA_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_LEARNING: r_learning <= pwdata[0];
                REG_ALPHA:    r_alpha    <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_sel)
            REG_LEARNING: prdata = {31'd0, r_learning};
            REG_ALPHA:    prdata = {16'd0, r_alpha};
            default:      prdata = '0;
        endcase
    end

    rcms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rcms_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_learning       (r_learning),
        .i_alpha          (r_alpha),
        .i_shaft_encoding (i_shaft_encoding),
        .i_range_bin      (i_range_bin),
        .i_sample         (i_sample),
        .i_radial_end     (i_radial_end),
        .i_out_stall      (i_stall),
        .o_valid          (o_valid),
        .o_corrected      (o_corrected),
        .o_corrected_last (o_corrected_last)
    );

endmodule
